>>> design/sri_pkg.sv
// ----------------------------------------------------------------------------
// sri_pkg
// shared constants and types of the snapshot ring interpolator
// ----------------------------------------------------------------------------
`default_nettype none
package sri_pkg;
  localparam int SLOTS_DEF = 8;
  localparam int MAX_PLAYERS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_COMMIT = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [32:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> design/sri_ram.sv
// ----------------------------------------------------------------------------
// sri_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module sri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> design/sri_div.sv
// ----------------------------------------------------------------------------
// sri_div
// restoring divider for the interpolation weight, one quotient bit per cycle
// ----------------------------------------------------------------------------
// num must be below den; the quotient is floor(num * 2^FRAC_BITS / den)
`default_nettype none
module sri_div #(
  parameter int FRAC_BITS = sri_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sri_pkg::div_req_t req,
  output sri_pkg::div_rsp_t      rsp
);
  import sri_pkg::*;
  logic [32:0] quot, den, rem;
  logic [5:0] cnt;
  logic run, fin;
  logic [33:0] shifted, trial;
  always_comb begin
    shifted = {rem, 1'b0};
    trial = shifted - {1'b0, den};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= run && !req.start && (cnt == 6'd1);
      if (req.start) begin
        run <= 1'b1;
        quot <= '0;
        den <= req.den;
        rem <= req.num;
        cnt <= 6'(FRAC_BITS);
      end else if (run) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quot <= {quot[31:0], 1'b1};
        end else begin
          rem <= shifted[32:0];
          quot <= {quot[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) run <= 1'b0;
      end
    end
  end
  assign rsp = '{done: fin, quot: quot};
endmodule
`default_nettype wire

>>> design/snapshot_ring_interpolator_unit.sv
// ----------------------------------------------------------------------------
// snapshot_ring_interpolator_unit
// ring of timestamped snapshots with per-player linear interpolation
// ----------------------------------------------------------------------------
// Each transaction gives one result, strobed by done for one cycle; the
// receiver cannot stall. Append and commit pass through the write state and
// then the done state. A query scans the slots one per cycle, then walks the
// two entry lists through the shared entry ram, each entry by address,
// registered read and compare, then runs the restoring divider and two
// multiply steps before it passes through the done state.
`default_nettype none
module snapshot_ring_interpolator_unit #(
  parameter int SLOTS = sri_pkg::SLOTS_DEF,
  parameter int MAX_PLAYERS = sri_pkg::MAX_PLAYERS_DEF,
  parameter int FRAC_BITS = sri_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic [31:0]        tick,
  input  wire logic [31:0]        entity_id,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  output logic                    done,
  output logic                    found,
  output logic signed [31:0]      sample_x,
  output logic signed [31:0]      sample_y,
  output logic [3:0]              stored_count,
  output logic                    dropped
);
  import sri_pkg::*;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
  localparam int CW = $clog2(MAX_PLAYERS + 1);
  localparam int DEPTH = SLOTS * MAX_PLAYERS;
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(SLOTS + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_SCAN = 10'b0000000010,
    S_FIND = 10'b0000000100, S_FWAIT = 10'b0000001000,
    S_FCHK = 10'b0000010000, S_DIV = 10'b0000100000,
    S_MULX = 10'b0001000000, S_MULY = 10'b0010000000,
    S_DONE = 10'b0100000000, S_WR = 10'b1000000000
  } state_t;
  state_t state;

  logic [SLOTS-1:0] slot_filled;
  logic [31:0] slot_tick [SLOTS];
  logic [CW-1:0] slot_entries [SLOTS];
  logic [SW-1:0] write_slot;
  logic [CW-1:0] build_count;

  logic [1:0] q_mode;
  logic [31:0] q_tick, q_id;
  logic [31:0] q_x, q_y;
  logic [SW-1:0] scan;
  logic a_ok, b_ok;
  logic [SW-1:0] a_slot, b_slot;
  logic pass; // 0 searches a, 1 searches b
  logic [CW-1:0] ecnt;
  logic ea_ok, eb_ok;
  logic [31:0] ax, ay, bx, by;
  logic [FRAC_BITS-1:0] alpha;
  logic signed [31:0] rx, ry;
  logic rfound, rdropped;

  logic we;
  logic [AW-1:0] addr;
  logic [95:0] rdata;
  div_req_t dreq;
  div_rsp_t drsp;

  sri_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata({q_id, q_x, q_y}), .rdata(rdata));
  sri_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [SW-1:0] cur_slot;
  always_comb begin
    cur_slot = pass ? b_slot : a_slot;
    if (state == S_WR)
      addr = AW'(write_slot * MAX_PLAYERS + build_count[PW-1:0]);
    else
      addr = AW'(cur_slot * MAX_PLAYERS + ecnt[PW-1:0]);
    we = (state == S_WR) && (q_mode == MODE_APPEND) && (build_count < CW'(MAX_PLAYERS));
  end

  // lerp step: a + floor((b-a)*alpha >> frac)
  logic signed [32:0] dif;
  logic signed [FRAC_BITS+33:0] prod;
  logic signed [31:0] lres;
  always_comb begin
    if (state == S_MULX) dif = $signed({bx[31], bx}) - $signed({ax[31], ax});
    else dif = $signed({by[31], by}) - $signed({ay[31], ay});
    prod = dif * $signed({1'b0, alpha});
    lres = 32'((state == S_MULX ? $signed(ax) : $signed(ay)) + 32'(prod >>> FRAC_BITS));
  end

  logic [NW-1:0] nfill;
  always_comb begin
    nfill = '0;
    for (int i = 0; i < SLOTS; i++) nfill = nfill + NW'(slot_filled[i]);
  end

  assign busy = (state != S_IDLE);
  logic [31:0] st;
  assign st = slot_tick[scan];
  logic [CW-1:0] elim;
  assign elim = slot_entries[cur_slot];

  // end of the current list walk, and the start of the weight division
  logic fend, div_go;
  assign fend = !(pass ? b_ok : a_ok) || ecnt >= elim || ecnt >= CW'(MAX_PLAYERS);
  assign div_go = (state == S_FIND) && fend && !(!pass && b_ok) &&
                  a_ok && b_ok && ea_ok && eb_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_filled <= '0;
      write_slot <= '0;
      build_count <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: if (start) begin
          q_mode <= mode; q_tick <= tick; q_id <= entity_id;
          q_x <= pos_x; q_y <= pos_y;
          rx <= '0; ry <= '0; rfound <= 1'b0; rdropped <= 1'b0;
          a_ok <= 1'b0; b_ok <= 1'b0; scan <= '0;
          ea_ok <= 1'b0; eb_ok <= 1'b0; pass <= 1'b0; ecnt <= '0;
          state <= (mode == MODE_QUERY) ? S_SCAN : S_WR;
        end
        S_WR: begin
          if (q_mode == MODE_APPEND) begin
            if (build_count >= CW'(MAX_PLAYERS)) rdropped <= 1'b1;
            else begin
              if (build_count == '0) slot_filled[write_slot] <= 1'b0;
              build_count <= build_count + CW'(1);
              rfound <= 1'b1;
            end
          end else if (q_mode == MODE_COMMIT) begin
            slot_tick[write_slot] <= q_tick;
            slot_entries[write_slot] <= build_count;
            slot_filled[write_slot] <= 1'b1;
            write_slot <= (write_slot == SW'(SLOTS - 1)) ? '0 : write_slot + SW'(1);
            build_count <= '0;
            rfound <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (slot_filled[scan]) begin
            if (st <= q_tick) begin
              if (!a_ok || st > slot_tick[a_slot]) begin a_ok <= 1'b1; a_slot <= scan; end
            end else if (!b_ok || st < slot_tick[b_slot]) begin
              b_ok <= 1'b1; b_slot <= scan;
            end
          end
          if (scan == SW'(SLOTS - 1)) begin
            state <= S_FIND;
            pass <= !(a_ok || (slot_filled[scan] && st <= q_tick));
          end else scan <= scan + SW'(1);
        end
        S_FIND: begin
          if (fend) begin
            if (!pass && b_ok) begin pass <= 1'b1; ecnt <= '0; end
            else if (a_ok && b_ok && ea_ok && eb_ok) begin
              state <= S_DIV;
            end else begin
              rfound <= eb_ok || (ea_ok && !b_ok);
              if (eb_ok) begin rx <= bx; ry <= by; end
              else if (ea_ok && !b_ok) begin rx <= ax; ry <= ay; end
              state <= S_DONE;
            end
          end else state <= S_FWAIT;
        end
        S_FWAIT: state <= S_FCHK;
        S_FCHK: begin
          if (rdata[95:64] == q_id) begin
            if (pass) begin eb_ok <= 1'b1; bx <= rdata[63:32]; by <= rdata[31:0]; end
            else begin ea_ok <= 1'b1; ax <= rdata[63:32]; ay <= rdata[31:0]; end
            ecnt <= CW'(MAX_PLAYERS);
          end else ecnt <= ecnt + CW'(1);
          state <= S_FIND;
        end
        S_DIV: if (drsp.done) begin
          alpha <= drsp.quot[FRAC_BITS-1:0];
          state <= S_MULX;
        end
        S_MULX: begin rx <= lres; state <= S_MULY; end
        S_MULY: begin ry <= lres; rfound <= 1'b1; state <= S_DONE; end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    dreq.start = div_go;
    dreq.num = {1'b0, q_tick - slot_tick[a_slot]};
    dreq.den = {1'b0, slot_tick[b_slot] - slot_tick[a_slot]};
  end

  always_ff @(posedge clk) begin
    found <= rfound;
    sample_x <= rx;
    sample_y <= ry;
    dropped <= rdropped;
    stored_count <= (nfill > NW'(15)) ? 4'd15 : 4'(nfill);
  end
endmodule
`default_nettype wire

>>> design/sri_checker.sv
// ----------------------------------------------------------------------------
// sri_checker
// port level checks of the snapshot ring interpolator
// ----------------------------------------------------------------------------
`default_nettype none
module sri_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic found,
  input wire logic dropped
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_drop_found: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> !found) else $error("dropped append reported found");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");
endmodule

bind snapshot_ring_interpolator_unit sri_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .found(found), .dropped(dropped));
`default_nettype wire
